// ===== sv/lspc_pkg.sv =====
// shared widths, codes, constants and control types of the looping sample position counter
`default_nettype none
package lspc_pkg;

   // field widths of the channels
   localparam int ACTION_W    = 3;
   localparam int COUNT_W     = 16;
   localparam int POSITION_W  = 48;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   // register widths
   localparam int RATE_W      = 19;
   localparam int TEMPO_W     = 17;
   localparam int BEATS_W     = 24;

   // conversion datapath widths
   localparam int EFF_END_W   = BEATS_W + 1;    // start plus a quarter beat may carry
   localparam int RATE6K_W    = 32;             // rate * 6000 stays below 2^32
   localparam int NUM_BITS    = 57;             // beats * rate * 6000 stays below 2^57
   localparam int DEN_SHIFT   = 8;
   localparam int DEN_W       = TEMPO_W + DEN_SHIFT;

   // constants
   localparam logic [RATE6K_W-1:0]  TIME_SCALE      = 32'd6000;    // 60 s times centi-bpm
   localparam logic [EFF_END_W-1:0] QUARTER_BEAT_Q8 = 25'd64;
   localparam logic [TEMPO_W-1:0]   TEMPO_MIN       = 17'd2000;
   localparam logic [TEMPO_W-1:0]   TEMPO_MAX       = 17'd99900;

   // register reset values
   localparam logic [RATE_W-1:0]  RATE_RESET     = 19'd48000;
   localparam logic [TEMPO_W-1:0] TEMPO_RESET    = 17'd12000;
   localparam logic [BEATS_W-1:0] LOOP_END_RESET = 24'd1024;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SAMPLE_RATE = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_TEMPO       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LOOP_ENABLE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LOOP_START  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_LOOP_END    = 3'd4;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_ADVANCE = 3'd0;
   localparam logic [ACTION_W-1:0] ACT_PLAY    = 3'd1;
   localparam logic [ACTION_W-1:0] ACT_PAUSE   = 3'd2;
   localparam logic [ACTION_W-1:0] ACT_STOP    = 3'd3;
   localparam logic [ACTION_W-1:0] ACT_SEEK    = 3'd4;

   typedef struct packed {
      logic accept;      // latch request and apply plain updates
      logic prep;        // rate * 6000, denominator, effective end
      logic mul_s;       // numerator for loop start
      logic mul_e;       // numerator for loop end
      logic div_start;
      logic div_mod;     // divider operands: position offset over loop length
      logic take_s;
      logic take_e;
      logic check;
      logic take_mod;
      logic load_rsp;
   } lspc_cmd_type;

   typedef struct packed {
      logic need_wrap;
      logic div_done;
      logic skip_mod;
   } lspc_sts_type;

endpackage
`default_nettype wire

// ===== sv/lspc_ifs.sv =====
// request, response and register write channels of the looping sample position counter
`default_nettype none
interface lspc_req_if;
   logic                                valid;
   logic                                ready;
   logic [lspc_pkg::ACTION_W-1:0]       action;
   logic [lspc_pkg::COUNT_W-1:0]        advance_count;
   logic [lspc_pkg::POSITION_W-1:0]     seek_position;

   modport source (output valid, action, advance_count, seek_position, input ready);
   modport sink   (input valid, action, advance_count, seek_position, output ready);
endinterface

interface lspc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [lspc_pkg::POSITION_W-1:0]     position;
   logic                                is_playing;

   modport source (output valid, position, is_playing, input ready);
   modport sink   (input valid, position, is_playing, output ready);
endinterface

interface lspc_csr_if;
   logic                                valid;
   logic                                ready;
   logic [lspc_pkg::CSR_INDEX_W-1:0]    index;
   logic [lspc_pkg::CSR_DATA_W-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/lspc_div.sv =====
// serial restoring divider, one quotient bit per cycle
`default_nettype none
module lspc_div #(
   parameter int W = 57
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire logic [W-1:0] dividend,
   input  wire logic [W-1:0] divisor,
   output logic              done,
   output logic [W-1:0]      quot,
   output logic [W-1:0]      rem
);
   localparam int CntW = $clog2(W + 1);

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]    acc_ff, acc_in;
   logic [W-1:0]    q_ff, q_in;
   logic [W-1:0]    d_ff, d_in;

   logic [W:0]      shifted;
   logic [W:0]      trial;
   logic            ge;

   always_comb begin
      shifted = {acc_ff, q_ff[W-1]};
      trial   = shifted - {1'b0, d_ff};
      ge      = shifted >= {1'b0, d_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      q_in    = q_ff;
      d_in    = d_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CntW'(W);
         acc_in  = '0;
         q_in    = dividend;
         d_in    = divisor;
      end else if (busy_ff) begin
         acc_in = ge ? trial[W-1:0] : shifted[W-1:0];
         q_in   = {q_ff[W-2:0], ge};
         cnt_in = cnt_ff - CntW'(1);
         if (cnt_ff == CntW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
   assign rem  = acc_ff;
endmodule
`default_nettype wire

// ===== sv/lspc_datapath.sv =====
// registers, transport state, beat to sample conversion and loop wrap datapath
`default_nettype none
module lspc_datapath #(
   parameter int POS_BITS = 48
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire lspc_pkg::lspc_cmd_type               cmd,
   output lspc_pkg::lspc_sts_type                    sts,
   input  wire logic [lspc_pkg::ACTION_W-1:0]        req_action,
   input  wire logic [lspc_pkg::COUNT_W-1:0]         req_advance_count,
   input  wire logic [lspc_pkg::POSITION_W-1:0]      req_seek_position,
   input  wire logic                                 csr_we,
   input  wire logic [lspc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [lspc_pkg::CSR_DATA_W-1:0]      csr_data,
   output logic [lspc_pkg::POSITION_W-1:0]           rsp_position,
   output logic                                      rsp_is_playing
);
   localparam int DivW = (POS_BITS > lspc_pkg::NUM_BITS) ? POS_BITS : lspc_pkg::NUM_BITS;

   // registers
   logic [lspc_pkg::RATE_W-1:0]    rate_ff, rate_in;
   logic [lspc_pkg::TEMPO_W-1:0]   tempo_ff, tempo_in;
   logic                           loop_en_ff, loop_en_in;
   logic [lspc_pkg::BEATS_W-1:0]   start_ff, start_in;
   logic [lspc_pkg::BEATS_W-1:0]   end_ff, end_in;

   // transport state
   logic                           play_ff, play_in;
   logic [POS_BITS-1:0]            pos_ff, pos_in;

   // working registers
   logic [POS_BITS-1:0]            cand_ff, cand_in;
   logic [lspc_pkg::RATE6K_W-1:0]  rate6k_ff, rate6k_in;
   logic [lspc_pkg::EFF_END_W-1:0] eff_end_ff, eff_end_in;
   logic [lspc_pkg::NUM_BITS-1:0]  num_ff, num_in;
   logic [lspc_pkg::DEN_W-1:0]     den_ff, den_in;
   logic [lspc_pkg::NUM_BITS-1:0]  s_ff, s_in;
   logic [lspc_pkg::NUM_BITS-1:0]  len_ff, len_in;
   logic [DivW-1:0]                diff_ff, diff_in;
   logic [lspc_pkg::POSITION_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic                           rsp_play_ff, rsp_play_in;

   logic                           wrap_on;
   logic [POS_BITS-1:0]            cand_next;
   logic [lspc_pkg::TEMPO_W-1:0]   tempo_wr;
   logic [lspc_pkg::EFF_END_W-1:0] start_plus;
   logic [lspc_pkg::EFF_END_W-1:0] mul_b;
   logic [DivW-1:0]                div_a;
   logic [DivW-1:0]                div_b;
   logic                           div_done;
   logic [DivW-1:0]                div_quot;
   logic [DivW-1:0]                div_rem;
   logic                           below_start;

   lspc_div #(.W(DivW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_a),
      .divisor  (div_b),
      .done     (div_done),
      .quot     (div_quot),
      .rem      (div_rem)
   );

   always_comb begin
      wrap_on     = loop_en_ff && (rate_ff != '0);
      cand_next   = (req_action == lspc_pkg::ACT_SEEK) ? POS_BITS'(req_seek_position)
                                                       : pos_ff + POS_BITS'(req_advance_count);
      tempo_wr    = csr_data[lspc_pkg::TEMPO_W-1:0];
      start_plus  = lspc_pkg::EFF_END_W'(start_ff) + lspc_pkg::QUARTER_BEAT_Q8;
      mul_b       = cmd.mul_e ? eff_end_ff : lspc_pkg::EFF_END_W'(start_ff);
      div_a       = cmd.div_mod ? diff_ff : DivW'(num_ff);
      div_b       = cmd.div_mod ? DivW'(len_ff) : DivW'(den_ff);
      below_start = DivW'(cand_ff) < DivW'(s_ff);

      sts.need_wrap = wrap_on && ((req_action == lspc_pkg::ACT_SEEK) ||
                                  ((req_action == lspc_pkg::ACT_ADVANCE) && play_ff));
      sts.div_done  = div_done;
      sts.skip_mod  = (len_ff == '0) || below_start;

      rate_in     = rate_ff;
      tempo_in    = tempo_ff;
      loop_en_in  = loop_en_ff;
      start_in    = start_ff;
      end_in      = end_ff;
      play_in     = play_ff;
      pos_in      = pos_ff;
      cand_in     = cand_ff;
      rate6k_in   = rate6k_ff;
      eff_end_in  = eff_end_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      s_in        = s_ff;
      len_in      = len_ff;
      diff_in     = diff_ff;
      rsp_pos_in  = rsp_pos_ff;
      rsp_play_in = rsp_play_ff;

      if (csr_we) begin
         case (csr_index)
            lspc_pkg::REG_SAMPLE_RATE: rate_in = csr_data[lspc_pkg::RATE_W-1:0];
            lspc_pkg::REG_TEMPO: begin
               if (tempo_wr < lspc_pkg::TEMPO_MIN) begin
                  tempo_in = lspc_pkg::TEMPO_MIN;
               end else if (tempo_wr > lspc_pkg::TEMPO_MAX) begin
                  tempo_in = lspc_pkg::TEMPO_MAX;
               end else begin
                  tempo_in = tempo_wr;
               end
            end
            lspc_pkg::REG_LOOP_ENABLE: loop_en_in = csr_data[0];
            lspc_pkg::REG_LOOP_START:  start_in = csr_data[lspc_pkg::BEATS_W-1:0];
            lspc_pkg::REG_LOOP_END:    end_in = csr_data[lspc_pkg::BEATS_W-1:0];
            default: ;
         endcase
      end

      // plain updates take effect at once, wrapped ones go through the divider
      if (cmd.accept) begin
         cand_in = cand_next;
         case (req_action)
            lspc_pkg::ACT_ADVANCE: begin
               if (play_ff && !wrap_on) begin
                  pos_in = cand_next;
               end
            end
            lspc_pkg::ACT_PLAY:  play_in = 1'b1;
            lspc_pkg::ACT_PAUSE: play_in = 1'b0;
            lspc_pkg::ACT_STOP: begin
               play_in = 1'b0;
               pos_in  = '0;
            end
            lspc_pkg::ACT_SEEK: begin
               if (!wrap_on) begin
                  pos_in = cand_next;
               end
            end
            default: ;
         endcase
      end

      if (cmd.prep) begin
         rate6k_in  = lspc_pkg::RATE6K_W'(rate_ff) * lspc_pkg::TIME_SCALE;
         den_in     = lspc_pkg::DEN_W'(tempo_ff) << lspc_pkg::DEN_SHIFT;
         eff_end_in = (lspc_pkg::EFF_END_W'(end_ff) > start_plus) ?
                      lspc_pkg::EFF_END_W'(end_ff) : start_plus;
      end

      if (cmd.mul_s || cmd.mul_e) begin
         num_in = lspc_pkg::NUM_BITS'(rate6k_ff) * lspc_pkg::NUM_BITS'(mul_b);
      end

      if (cmd.take_s) begin
         s_in = div_quot[lspc_pkg::NUM_BITS-1:0];
      end

      if (cmd.take_e) begin
         len_in = div_quot[lspc_pkg::NUM_BITS-1:0] - s_ff;
      end

      if (cmd.check) begin
         if (len_ff == '0) begin
            pos_in = cand_ff;
         end else if (below_start) begin
            pos_in = POS_BITS'(s_ff);
         end else begin
            diff_in = DivW'(cand_ff) - DivW'(s_ff);
         end
      end

      if (cmd.take_mod) begin
         pos_in = POS_BITS'(DivW'(s_ff) + div_rem);
      end

      if (cmd.load_rsp) begin
         rsp_pos_in  = lspc_pkg::POSITION_W'(pos_ff);
         rsp_play_in = play_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= lspc_pkg::RATE_RESET;
         tempo_ff   <= lspc_pkg::TEMPO_RESET;
         loop_en_ff <= 1'b0;
         start_ff   <= '0;
         end_ff     <= lspc_pkg::LOOP_END_RESET;
         play_ff    <= 1'b0;
         pos_ff     <= '0;
      end else begin
         rate_ff    <= rate_in;
         tempo_ff   <= tempo_in;
         loop_en_ff <= loop_en_in;
         start_ff   <= start_in;
         end_ff     <= end_in;
         play_ff    <= play_in;
         pos_ff     <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      rate6k_ff   <= rate6k_in;
      eff_end_ff  <= eff_end_in;
      num_ff      <= num_in;
      den_ff      <= den_in;
      s_ff        <= s_in;
      len_ff      <= len_in;
      diff_ff     <= diff_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_play_ff <= rsp_play_in;
   end

   assign rsp_position   = rsp_pos_ff;
   assign rsp_is_playing = rsp_play_ff;
endmodule
`default_nettype wire

// ===== sv/lspc_ctrl.sv =====
// sequencer for request intake, loop wrap steps and the response register
`default_nettype none
module lspc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output lspc_pkg::lspc_cmd_type      cmd,
   input  wire lspc_pkg::lspc_sts_type sts
);
   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_PREP   = 4'd1;
   localparam logic [3:0] ST_MUL_S  = 4'd2;
   localparam logic [3:0] ST_DIV_S  = 4'd3;
   localparam logic [3:0] ST_WAIT_S = 4'd4;
   localparam logic [3:0] ST_MUL_E  = 4'd5;
   localparam logic [3:0] ST_DIV_E  = 4'd6;
   localparam logic [3:0] ST_WAIT_E = 4'd7;
   localparam logic [3:0] ST_CHECK  = 4'd8;
   localparam logic [3:0] ST_DIV_M  = 4'd9;
   localparam logic [3:0] ST_WAIT_M = 4'd10;
   localparam logic [3:0] ST_OUT    = 4'd11;

   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      slot_free    = !rsp_valid_ff || rsp_ready;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = (state_ff == ST_IDLE);
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = sts.need_wrap ? ST_PREP : ST_OUT;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = ST_MUL_S;
         end
         ST_MUL_S: begin
            cmd.mul_s = 1'b1;
            state_in  = ST_DIV_S;
         end
         ST_DIV_S: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_S;
         end
         ST_WAIT_S: begin
            if (sts.div_done) begin
               cmd.take_s = 1'b1;
               state_in   = ST_MUL_E;
            end
         end
         ST_MUL_E: begin
            cmd.mul_e = 1'b1;
            state_in  = ST_DIV_E;
         end
         ST_DIV_E: begin
            cmd.div_start = 1'b1;
            state_in      = ST_WAIT_E;
         end
         ST_WAIT_E: begin
            if (sts.div_done) begin
               cmd.take_e = 1'b1;
               state_in   = ST_CHECK;
            end
         end
         ST_CHECK: begin
            cmd.check = 1'b1;
            state_in  = sts.skip_mod ? ST_OUT : ST_DIV_M;
         end
         ST_DIV_M: begin
            cmd.div_start = 1'b1;
            cmd.div_mod   = 1'b1;
            state_in      = ST_WAIT_M;
         end
         ST_WAIT_M: begin
            if (sts.div_done) begin
               cmd.take_mod = 1'b1;
               state_in     = ST_OUT;
            end
         end
         ST_OUT: begin
            // hold the result until the response register has room
            if (slot_free) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid_ff)
      else $error("response loaded without raising valid");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("pending response overwritten");

   a_div_then_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |=> (state_ff == ST_WAIT_S || state_ff == ST_WAIT_E ||
                         state_ff == ST_WAIT_M))
      else $error("divider started outside a divide step");
endmodule
`default_nettype wire

// ===== sv/looping_sample_position_counter.sv =====
// looping sample position counter: transport flag and sample position with loop wrapping
// Channels: req_ch takes one request (action, advance_count, seek_position); rsp_ch
// returns one result (position, is_playing) per request; csr_ch writes the five
// registers by index (0 sample rate, 1 tempo, 2 loop enable, 3 loop start, 4 loop end)
// and is always ready. Write registers only while no request is in flight.
// Play, pause, stop, unused actions, an advance while paused and any update with
// looping off skip the loop wrap and go straight from acceptance to the output step.
// A seek, or an advance while playing, with looping on and a nonzero sample rate runs
// the loop wrap: two beat to sample conversions and one modulo on a shared serial
// divider of W = max(57, POS_BITS) bits, one quotient bit a cycle. The modulo is
// skipped when the position snaps to the loop start or the loop is empty.
// One request is worked on at a time; the next is taken once the result of the
// previous one sits in the output register, even if it has not yet been taken.
// A stalled receiver holds the result register and, after one more request, the
// sequencer waits with its result until room appears.
// Reset (synchronous) stops the transport, clears the position and restores the
// register defaults: 48000 Hz, 120.00 bpm, looping off, loop 0 to 4 beats.
`default_nettype none
module looping_sample_position_counter #(
   parameter int POS_BITS = 48
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lspc_req_if.sink   req_ch,
   lspc_rsp_if.source rsp_ch,
   lspc_csr_if.sink   csr_ch
);
   lspc_pkg::lspc_cmd_type cmd;
   lspc_pkg::lspc_sts_type sts;

   assign csr_ch.ready = 1'b1;

   lspc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   lspc_datapath #(.POS_BITS(POS_BITS)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_action        (req_ch.action),
      .req_advance_count (req_ch.advance_count),
      .req_seek_position (req_ch.seek_position),
      .csr_we            (csr_ch.valid & csr_ch.ready),
      .csr_index         (csr_ch.index),
      .csr_data          (csr_ch.data),
      .rsp_position      (rsp_ch.position),
      .rsp_is_playing    (rsp_ch.is_playing)
   );
endmodule
`default_nettype wire
